/* design/ps2sk_pkg.sv */
`default_nettype none
package ps2sk_pkg;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_PREFIX       = 8'hE0;
  localparam logic [7:0] SC_UP           = 8'h48;
  localparam logic [7:0] SC_DOWN         = 8'h50;
  localparam logic [7:0] SC_LEFT         = 8'h4B;
  localparam logic [7:0] SC_RIGHT        = 8'h4D;

  localparam logic [7:0] ARROW_UP    = 8'h80;
  localparam logic [7:0] ARROW_DOWN  = 8'h81;
  localparam logic [7:0] ARROW_LEFT  = 8'h82;
  localparam logic [7:0] ARROW_RIGHT = 8'h83;

  localparam int unsigned TABLE_LEN = 58;
  localparam int unsigned IDX_W     = $clog2(TABLE_LEN);

  typedef logic [IDX_W-1:0] key_idx_t;

  // Unshifted key map; zero marks a key with no character.
  function automatic logic [7:0] map_plain(input key_idx_t idx);
    logic [7:0] k;
    case (idx)
      6'd1:  k = 8'h1B;
      6'd2:  k = 8'h31;
      6'd3:  k = 8'h32;
      6'd4:  k = 8'h33;
      6'd5:  k = 8'h34;
      6'd6:  k = 8'h35;
      6'd7:  k = 8'h36;
      6'd8:  k = 8'h37;
      6'd9:  k = 8'h38;
      6'd10: k = 8'h39;
      6'd11: k = 8'h30;
      6'd12: k = 8'h2D;
      6'd13: k = 8'h3D;
      6'd14: k = 8'h08;
      6'd15: k = 8'h09;
      6'd16: k = 8'h71;
      6'd17: k = 8'h77;
      6'd18: k = 8'h65;
      6'd19: k = 8'h72;
      6'd20: k = 8'h74;
      6'd21: k = 8'h79;
      6'd22: k = 8'h75;
      6'd23: k = 8'h69;
      6'd24: k = 8'h6F;
      6'd25: k = 8'h70;
      6'd26: k = 8'h5B;
      6'd27: k = 8'h5D;
      6'd28: k = 8'h0A;
      6'd30: k = 8'h61;
      6'd31: k = 8'h73;
      6'd32: k = 8'h64;
      6'd33: k = 8'h66;
      6'd34: k = 8'h67;
      6'd35: k = 8'h68;
      6'd36: k = 8'h6A;
      6'd37: k = 8'h6B;
      6'd38: k = 8'h6C;
      6'd39: k = 8'h3B;
      6'd40: k = 8'h27;
      6'd41: k = 8'h60;
      6'd43: k = 8'h5C;
      6'd44: k = 8'h7A;
      6'd45: k = 8'h78;
      6'd46: k = 8'h63;
      6'd47: k = 8'h76;
      6'd48: k = 8'h62;
      6'd49: k = 8'h6E;
      6'd50: k = 8'h6D;
      6'd51: k = 8'h2C;
      6'd52: k = 8'h2E;
      6'd53: k = 8'h2F;
      6'd55: k = 8'h2A;
      6'd57: k = 8'h20;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // Caps lock only raises letters.
  function automatic logic [7:0] map_caps(input key_idx_t idx);
    logic [7:0] k;
    k = map_plain(idx);
    if (k >= 8'h61 && k <= 8'h7A) begin
      k = k - 8'h20;
    end
    return k;
  endfunction

  function automatic logic [7:0] map_shifted(input key_idx_t idx);
    logic [7:0] k;
    case (idx)
      6'd2:  k = 8'h21;
      6'd3:  k = 8'h40;
      6'd4:  k = 8'h23;
      6'd5:  k = 8'h24;
      6'd6:  k = 8'h25;
      6'd7:  k = 8'h5E;
      6'd8:  k = 8'h26;
      6'd9:  k = 8'h2A;
      6'd10: k = 8'h28;
      6'd11: k = 8'h29;
      6'd12: k = 8'h5F;
      6'd13: k = 8'h2B;
      6'd26: k = 8'h7B;
      6'd27: k = 8'h7D;
      6'd39: k = 8'h3A;
      6'd40: k = 8'h22;
      6'd41: k = 8'h7E;
      6'd43: k = 8'h7C;
      6'd51: k = 8'h3C;
      6'd52: k = 8'h3E;
      6'd53: k = 8'h3F;
      default: k = map_caps(idx);
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* design/ps2_scancode_to_key_unit.sv */
`default_nettype none
// Scancode (set 1) to key code converter.
// Input channel: in_valid / in_ready with one scancode byte per request.
// Output channel: out_valid / out_ready with one key_code per request.
// Each accepted byte either yields one key code or nothing: shift, caps
// lock, the 0xE0 prefix, break codes, unmapped codes and any byte after the
// prefix other than the four arrows produce no output request.
// The output is registered: a byte that yields a key and is accepted at one
// edge shows it on key_code with out_valid high right after that edge.
// Throughput is one byte per cycle while no key is stalled; the lookup and
// the flag updates sit between the input handshake and the output register.
// The output register also serves as the decoupling stage: a new byte is
// taken whenever the register is empty or is being drained in the same
// cycle. While the receiver stalls with a key pending, in_ready is low and
// the pending key holds.
// Reset (rst, synchronous, active high) clears the shift, caps-lock and
// prefix flags and empties the output register.
module ps2_scancode_to_key_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] scancode,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      key_code
);
  import ps2sk_pkg::*;

  logic       shift_held, shift_held_next;
  logic       caps_on, caps_on_next;
  logic       prefix_pending, prefix_pending_next;
  logic [7:0] key;
  logic       in_fire;
  key_idx_t   idx;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign idx      = scancode[IDX_W-1:0];

  always_comb begin
    shift_held_next     = shift_held;
    caps_on_next        = caps_on;
    prefix_pending_next = 1'b0;
    key                 = 8'h00;
    if (prefix_pending) begin
      unique case (scancode)
        SC_UP:    key = ARROW_UP;
        SC_DOWN:  key = ARROW_DOWN;
        SC_LEFT:  key = ARROW_LEFT;
        SC_RIGHT: key = ARROW_RIGHT;
        default:  key = 8'h00;
      endcase
    end else begin
      unique case (scancode) inside
        SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_held_next = 1'b1;
        SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_held_next = 1'b0;
        SC_CAPS_MAKE:                     caps_on_next = !caps_on;
        SC_PREFIX:                        prefix_pending_next = 1'b1;
        default: begin
          if (scancode < 8'(TABLE_LEN)) begin
            if (shift_held) begin
              key = map_shifted(idx);
            end else if (caps_on) begin
              key = map_caps(idx);
            end else begin
              key = map_plain(idx);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      caps_on        <= 1'b0;
      prefix_pending <= 1'b0;
      out_valid      <= 1'b0;
    end else if (in_fire) begin
      shift_held     <= shift_held_next;
      caps_on        <= caps_on_next;
      prefix_pending <= prefix_pending_next;
      out_valid      <= (key != 8'h00);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_code <= key;
    end
  end

  // A stalled key code must not be overwritten by a new byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_code))
    else $error("pending key code changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_code != 8'h00)
    else $error("zero key code presented");

  assert property (@(posedge clk) disable iff (rst)
    in_fire && !prefix_pending && scancode == SC_PREFIX |=> prefix_pending && !out_valid)
    else $error("prefix byte not armed");

  assert property (@(posedge clk) disable iff (rst)
    in_fire && prefix_pending |=> !prefix_pending)
    else $error("prefix flag not cleared by following byte");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && key_code[7] |-> key_code == ARROW_UP || key_code == ARROW_DOWN ||
      key_code == ARROW_LEFT || key_code == ARROW_RIGHT)
    else $error("high key code is not an arrow");

endmodule
`default_nettype wire

/* tb/tb_ps2_scancode_to_key_unit.sv */
`timescale 1ns / 1ps

module tb_ps2_scancode_to_key_unit;
  import ps2sk_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned ITEMS_PER_RUN = 700;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam logic [7:0]  NO_KEY        = 8'h00;

  // Printable part of the plain and shifted maps, index 0 first. The control
  // keys (escape, backspace, tab, enter) are the same in every map and are
  // handled apart. A marker character stands for an empty slot.
  localparam logic [7:0] PLAIN_GAP = "$";
  localparam logic [7:0] SHIFT_GAP = ".";
  localparam logic [8*58-1:0] PLAIN_KEYS =
    "$$1234567890-=$$qwertyuiop[]$$asdfghjkl;'`$\\zxcvbnm,./$*$ ";
  localparam logic [8*58-1:0] SHIFT_KEYS =
    "..!@#$%^&*()_+..QWERTYUIOP{}..ASDFGHJKL:\"~.|ZXCVBNM<>?.*. ";

  typedef struct packed {
    logic [7:0] sc;
    logic       known;
    logic [7:0] key;
  } probe_t;

  localparam int N_PROBES = 29;
  localparam probe_t PROBES [N_PROBES] = '{
    '{8'h1E, 1'b1, 8'h61},
    '{8'h00, 1'b1, NO_KEY},
    '{8'h01, 1'b1, 8'h1B},
    '{8'h39, 1'b1, 8'h20},
    '{8'h3B, 1'b1, NO_KEY},
    '{SC_UP, 1'b1, NO_KEY},
    '{8'hFF, 1'b1, NO_KEY},
    '{8'h9E, 1'b1, NO_KEY},
    '{SC_PREFIX, 1'b1, NO_KEY},
    '{SC_UP, 1'b1, ARROW_UP},
    '{SC_PREFIX, 1'b1, NO_KEY},
    '{SC_DOWN, 1'b1, ARROW_DOWN},
    '{SC_PREFIX, 1'b1, NO_KEY},
    '{SC_LEFT, 1'b1, ARROW_LEFT},
    '{SC_PREFIX, 1'b1, NO_KEY},
    '{SC_RIGHT, 1'b1, ARROW_RIGHT},
    '{SC_PREFIX, 1'b1, NO_KEY},
    '{SC_PREFIX, 1'b1, NO_KEY},
    '{8'h1E, 1'b1, 8'h61},
    '{SC_PREFIX, 1'b1, NO_KEY},
    '{SC_LSHIFT_MAKE, 1'b1, NO_KEY},
    '{8'h1E, 1'b1, 8'h61},
    '{SC_CAPS_MAKE, 1'b1, NO_KEY},
    '{8'h10, 1'b0, NO_KEY},
    '{SC_RSHIFT_MAKE, 1'b1, NO_KEY},
    '{8'h02, 1'b0, NO_KEY},
    '{SC_RSHIFT_BREAK, 1'b1, NO_KEY},
    '{SC_CAPS_MAKE, 1'b1, NO_KEY},
    '{8'h35, 1'b0, NO_KEY}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] scancode = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] key_code;

  // Keyboard state as the predictor sees it.
  logic shift_down = 1'b0;
  logic caps_active = 1'b0;
  logic after_prefix = 1'b0;

  logic [7:0]  pending_keys [$];
  logic [7:0]  want_key;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_go = 1'b0;

  ps2_scancode_to_key_unit uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .scancode (scancode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .key_code (key_code)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] map_lookup(input logic [5:0] idx, input logic shifted,
                                            input logic caps);
    logic [7:0] ch;
    case (idx)
      6'd1:  return 8'h1B;
      6'd14: return 8'h08;
      6'd15: return 8'h09;
      6'd28: return 8'h0A;
      default: ;
    endcase
    if (shifted) begin
      ch = SHIFT_KEYS[8*(57-idx) +: 8];
      if (ch == SHIFT_GAP) ch = NO_KEY;
    end else begin
      ch = PLAIN_KEYS[8*(57-idx) +: 8];
      if (ch == PLAIN_GAP) ch = NO_KEY;
      else if (caps && ch >= "a" && ch <= "z") ch = ch - 8'h20;
    end
    return ch;
  endfunction

  // Advances the keyboard state by one byte and gives the key it yields.
  task automatic decode_scancode(input logic [7:0] sc, output logic [7:0] key);
    key = NO_KEY;
    if (after_prefix) begin
      after_prefix = 1'b0;
      case (sc)
        SC_UP:    key = ARROW_UP;
        SC_DOWN:  key = ARROW_DOWN;
        SC_LEFT:  key = ARROW_LEFT;
        SC_RIGHT: key = ARROW_RIGHT;
        default:  key = NO_KEY;
      endcase
    end else if (sc == SC_LSHIFT_MAKE || sc == SC_RSHIFT_MAKE) begin
      shift_down = 1'b1;
    end else if (sc == SC_LSHIFT_BREAK || sc == SC_RSHIFT_BREAK) begin
      shift_down = 1'b0;
    end else if (sc == SC_CAPS_MAKE) begin
      caps_active = ~caps_active;
    end else if (sc == SC_PREFIX) begin
      after_prefix = 1'b1;
    end else if (!sc[7] && sc < TABLE_LEN) begin
      key = map_lookup(sc[5:0], shift_down, caps_active);
    end
  endtask

  // Offers one byte, waits for the request to be taken and records the key.
  task automatic send_scancode(input logic [7:0] sc, input logic known,
                               input logic [7:0] known_key);
    logic [7:0] key;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    scancode <= sc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_scancode(sc, key);
    if (known) key = known_key;
    if (key != NO_KEY) pending_keys.push_back(key);
  endtask

  // Mostly typing-like traffic: make codes, shift and caps lock, arrow
  // sequences; the rest is break codes and raw bytes.
  task automatic send_random_keys(output int unsigned count);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    count = 1;
    if (pick < 45) begin
      send_scancode(8'($urandom_range(0, TABLE_LEN - 1)), 1'b0, NO_KEY);
    end else if (pick < 55) begin
      case ($urandom_range(0, 3))
        0: send_scancode(SC_LSHIFT_MAKE, 1'b0, NO_KEY);
        1: send_scancode(SC_RSHIFT_MAKE, 1'b0, NO_KEY);
        2: send_scancode(SC_LSHIFT_BREAK, 1'b0, NO_KEY);
        default: send_scancode(SC_RSHIFT_BREAK, 1'b0, NO_KEY);
      endcase
    end else if (pick < 60) begin
      send_scancode(SC_CAPS_MAKE, 1'b0, NO_KEY);
    end else if (pick < 72) begin
      send_scancode(SC_PREFIX, 1'b0, NO_KEY);
      case ($urandom_range(0, 3))
        0: send_scancode(SC_UP, 1'b0, NO_KEY);
        1: send_scancode(SC_DOWN, 1'b0, NO_KEY);
        2: send_scancode(SC_LEFT, 1'b0, NO_KEY);
        default: send_scancode(SC_RIGHT, 1'b0, NO_KEY);
      endcase
      count = 2;
    end else if (pick < 77) begin
      send_scancode(SC_PREFIX, 1'b0, NO_KEY);
      send_scancode(8'($urandom_range(0, 255)), 1'b0, NO_KEY);
      count = 2;
    end else if (pick < 87) begin
      send_scancode(8'($urandom_range(128, 255)), 1'b0, NO_KEY);
    end else begin
      send_scancode(8'($urandom_range(0, 255)), 1'b0, NO_KEY);
    end
  endtask

  task automatic run_random_phase();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < ITEMS_PER_RUN) begin
      send_random_keys(n);
      sent += n;
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_keys.size() == 0) begin
        $error("key_code: expected no request, actual %h", key_code);
        mismatches++;
      end else begin
        want_key = pending_keys.pop_front();
        if (key_code !== want_key) begin
          $error("key_code: expected %h, actual %h", want_key, key_code);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[ps2_scancode_to_key_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 81;
    for (int i = 0; i < N_PROBES; i++) begin
      send_scancode(PROBES[i].sc, PROBES[i].known, PROBES[i].key);
    end
    run_random_phase();

    send_idle_pct = 81;
    recv_idle_pct = 32;
    run_random_phase();

    // The receiver stalls for a long stretch so the output stage fills and
    // in_ready drops while requests keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_go = 1'b1;
    run_random_phase();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && pending_keys.size() == 0) begin
      $display("[ps2_scancode_to_key_unit] OK");
    end else begin
      $display("[ps2_scancode_to_key_unit] ERROR");
    end
    $finish;
  end

endmodule
